FILE: rtl/pcorr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcorr_pkg - shared constants and types of the correlation block
// Sizes of the sample, sum and product words; the sum and product widths follow the pair limit.
// ----------------------------------------------------------------------------
package pcorr_pkg;

	// Largest number of pairs that enter the sums of one series.
	localparam int N_MAX   = 1024;

	// Sample and result widths.
	localparam int SMP_W   = 16;
	localparam int COEF_W  = 16;

	// Pair counter, able to hold N_MAX itself.
	localparam int CNT_W   = $clog2(N_MAX + 1);

	// Running sums: x and y, x*x and y*y (never negative), x*y (signed).
	localparam int SUM_W   = SMP_W + CNT_W;
	localparam int SQ_W    = 2 * SMP_W - 2 + CNT_W;
	localparam int XY_W    = SQ_W + 1;

	// Magnitude of the variance terms and of the covariance term.
	localparam int U_W     = CNT_W + SQ_W;

	// Working word of the shared adder: holds u*v scaled by 2^32 with headroom.
	localparam int FRAC_SH = 32;
	localparam int BIG_W   = 2 * U_W + FRAC_SH + 3;

	// The root search finds a 17-bit integer, one bit per step.
	localparam int KEY_W   = FRAC_SH / 2 + 1;
	localparam int BIT_W   = $clog2(KEY_W);

	// Saturation limit of the Q1.15 result.
	localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W - 1){1'b1}}};

	typedef logic [BIG_W-1:0] word_t;

endpackage

FILE: rtl/pcorr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcorr_if - valid/ready channels of the correlation block
// One channel carries sample pairs in, the other carries one result per series.
// ----------------------------------------------------------------------------
interface pcorr_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [pcorr_pkg::SMP_W-1:0] sample_x;
	logic signed [pcorr_pkg::SMP_W-1:0] sample_y;
	logic                              last_pair;

	modport source (output valid, output sample_x, output sample_y, output last_pair,
		input ready);
	modport sink (input valid, input sample_x, input sample_y, input last_pair,
		output ready);
endinterface

interface pcorr_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [pcorr_pkg::COEF_W-1:0] coefficient;
	logic                               flat_series;
	logic                               too_long;

	modport source (output valid, output coefficient, output flat_series,
		output too_long, input ready);
	modport sink (input valid, input coefficient, input flat_series, input too_long,
		output ready);
endinterface

FILE: rtl/pcorr_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcorr_alu - shared wide add/subtract unit
// Every multiply step and root trial of the block, and the sign removal of
// the covariance term, pass through this one adder.
// ----------------------------------------------------------------------------
module pcorr_alu (
	input  pcorr_pkg::word_t op_a,
	input  pcorr_pkg::word_t op_b,
	input  logic             sub,
	output pcorr_pkg::word_t total
);

	// Two's complement add, or subtract by inverting op_b and carrying in one.
	assign total = op_a + (op_b ^ {pcorr_pkg::BIG_W{sub}}) + pcorr_pkg::BIG_W'(sub);

endmodule

FILE: rtl/pearson_correlation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pearson_correlation - Pearson coefficient of two paired sample series
// Accumulates count and exact sums per pair and, on the pair marked last,
// returns the coefficient in signed Q1.15 with flat and too-long flags.
// ----------------------------------------------------------------------------
// Every product is formed by a shift-add multiplier built round one shared
// wide adder, one multiplier bit per cycle. A pair runs three multiplications,
// each stepping once per significant bit of the sample magnitudes; a pair
// beyond N_MAX runs none. The last pair then adds six products for the two
// variance terms and the covariance term and, unless the series is flat, the
// products u*v and w*w and 17 root steps of three or four adder passes each.
// The pair input is ready only while the block is idle; a result waits in an
// output register, so the next series may start before it is taken.
// ----------------------------------------------------------------------------
module pearson_correlation (
	input  logic               clk,
	input  logic               arst_n,
	pcorr_in_if.sink           pairs,
	pcorr_out_if.source        result
);

	// Sequencer states.
	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_XX   = 5'd1;
	localparam logic [4:0] ST_YY   = 5'd2;
	localparam logic [4:0] ST_XY   = 5'd3;
	localparam logic [4:0] ST_U1   = 5'd4;
	localparam logic [4:0] ST_U2   = 5'd5;
	localparam logic [4:0] ST_V1   = 5'd6;
	localparam logic [4:0] ST_V2   = 5'd7;
	localparam logic [4:0] ST_W1   = 5'd8;
	localparam logic [4:0] ST_W2   = 5'd9;
	localparam logic [4:0] ST_WABS = 5'd10;
	localparam logic [4:0] ST_UV   = 5'd11;
	localparam logic [4:0] ST_WW   = 5'd12;
	localparam logic [4:0] ST_R1   = 5'd13;
	localparam logic [4:0] ST_R2   = 5'd14;
	localparam logic [4:0] ST_R3   = 5'd15;
	localparam logic [4:0] ST_R4   = 5'd16;
	localparam logic [4:0] ST_DONE = 5'd17;

	localparam int SMP_W  = pcorr_pkg::SMP_W;
	localparam int COEF_W = pcorr_pkg::COEF_W;
	localparam int CNT_W  = pcorr_pkg::CNT_W;
	localparam int SUM_W  = pcorr_pkg::SUM_W;
	localparam int SQ_W   = pcorr_pkg::SQ_W;
	localparam int XY_W   = pcorr_pkg::XY_W;
	localparam int U_W    = pcorr_pkg::U_W;
	localparam int BIG_W  = pcorr_pkg::BIG_W;
	localparam int KEY_W  = pcorr_pkg::KEY_W;
	localparam int BIT_W  = pcorr_pkg::BIT_W;

	// Control state and running sums.
	logic [4:0]              state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [SUM_W-1:0] sx_q;
	logic signed [SUM_W-1:0] sy_q;
	logic [SQ_W-1:0]         sxx_q;
	logic [SQ_W-1:0]         syy_q;
	logic signed [XY_W-1:0]  sxy_q;
	logic                    ovf_q;
	logic                    ovalid_q;

	// Captured pair.
	logic signed [SMP_W-1:0] x_q;
	logic signed [SMP_W-1:0] y_q;
	logic                    last_q;

	// Shift-add multiplier: accumulator, multiplicand, multiplier, sign.
	pcorr_pkg::word_t        acc_q;
	pcorr_pkg::word_t        a_q;
	logic [U_W-1:0]          b_q;
	logic                    sub_q;

	// Final terms and root search.
	logic [U_W-1:0]          u_q;
	logic [U_W-1:0]          v_q;
	logic [U_W-1:0]          wmag_q;
	logic                    wneg_q;
	logic                    flat_q;
	logic [2*U_W-1:0]        uv_q;
	pcorr_pkg::word_t        ww_q;
	pcorr_pkg::word_t        p_q;
	pcorr_pkg::word_t        r_q;
	pcorr_pkg::word_t        s_q;
	logic [KEY_W-1:0]        k_q;
	logic [BIT_W-1:0]        bit_q;

	// Output register.
	logic signed [COEF_W-1:0] coef_q;
	logic                     flat_out_q;
	logic                     long_out_q;

	// Combinational signals.
	logic                    in_beat;
	logic                    room;
	logic                    out_free;
	logic [SMP_W-1:0]        in_x_mag;
	logic [SMP_W-1:0]        x_mag;
	logic [SMP_W-1:0]        y_mag;
	logic [SUM_W-1:0]        sx_mag;
	logic [SUM_W-1:0]        sy_mag;
	logic [XY_W-1:0]         sxy_mag;
	pcorr_pkg::word_t        alu_a;
	pcorr_pkg::word_t        alu_b;
	logic                    alu_sub;
	pcorr_pkg::word_t        alu_sum;
	logic                    mac_busy;
	logic                    mac_last;
	pcorr_pkg::word_t        mac_acc_nxt;
	logic [KEY_W-1:0]        half_k;
	logic [COEF_W-1:0]       mag_sat;

	// Handshake.
	assign pairs.ready        = (state_q == ST_IDLE);
	assign in_beat            = pairs.valid && pairs.ready;
	assign room               = (cnt_q < CNT_W'(pcorr_pkg::N_MAX));
	assign out_free           = !ovalid_q || result.ready;
	assign result.valid       = ovalid_q;
	assign result.coefficient = coef_q;
	assign result.flat_series = flat_out_q;
	assign result.too_long    = long_out_q;

	// Magnitudes of the samples and sums that feed the multiplier.
	assign in_x_mag = pairs.sample_x[SMP_W-1] ? SMP_W'(-pairs.sample_x) : pairs.sample_x;
	assign x_mag    = x_q[SMP_W-1] ? SMP_W'(-x_q) : x_q;
	assign y_mag    = y_q[SMP_W-1] ? SMP_W'(-y_q) : y_q;
	assign sx_mag   = sx_q[SUM_W-1] ? SUM_W'(-sx_q) : sx_q;
	assign sy_mag   = sy_q[SUM_W-1] ? SUM_W'(-sy_q) : sy_q;
	assign sxy_mag  = sxy_q[XY_W-1] ? XY_W'(-sxy_q) : sxy_q;

	// Operand selection for the shared adder.
	always_comb begin
		alu_a    = '0;
		alu_b    = '0;
		alu_sub  = 1'b0;
		mac_busy = 1'b0;
		unique case (state_q) inside
			ST_XX, ST_YY, ST_XY, ST_U1, ST_U2, ST_V1, ST_V2, ST_W1, ST_W2,
			ST_UV, ST_WW: begin
				alu_a    = acc_q;
				alu_b    = a_q;
				alu_sub  = sub_q;
				mac_busy = 1'b1;
			end
			ST_WABS: begin
				alu_b   = acc_q;
				alu_sub = acc_q[BIG_W-1];
			end
			ST_R1: begin
				alu_a = p_q;
				alu_b = r_q;
			end
			ST_R2: begin
				alu_a = acc_q;
				alu_b = s_q;
			end
			ST_R3: begin
				alu_a   = ww_q;
				alu_b   = acc_q;
				alu_sub = 1'b1;
			end
			ST_R4: begin
				alu_a = r_q >> 1;
				alu_b = s_q;
			end
			default: begin
			end
		endcase
	end

	pcorr_alu u_alu (
		.op_a  (alu_a),
		.op_b  (alu_b),
		.sub   (alu_sub),
		.total (alu_sum)
	);

	// One multiplier bit per cycle; the product ends when no bits remain.
	assign mac_last    = (b_q[U_W-1:1] == '0);
	assign mac_acc_nxt = b_q[0] ? alu_sum : acc_q;

	// Rounded magnitude from the root, saturated to the Q1.15 limit.
	assign half_k  = KEY_W'(k_q + 1'b1) >> 1;
	assign mag_sat = (half_k > KEY_W'(pcorr_pkg::COEF_MAX)) ? pcorr_pkg::COEF_MAX :
		half_k[COEF_W-1:0];

	// Sequencer, sums and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			sx_q     <= '0;
			sy_q     <= '0;
			sxx_q    <= '0;
			syy_q    <= '0;
			sxy_q    <= '0;
			ovf_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			// The output is set when a result is loaded and cleared when its beat is taken.
			if (state_q == ST_DONE && out_free) begin
				ovalid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						if (room) begin
							cnt_q   <= cnt_q + 1'b1;
							sx_q    <= sx_q + SUM_W'(pairs.sample_x);
							sy_q    <= sy_q + SUM_W'(pairs.sample_y);
							state_q <= ST_XX;
						end else begin
							ovf_q   <= 1'b1;
							state_q <= pairs.last_pair ? ST_U1 : ST_IDLE;
						end
					end
				end
				ST_XX: begin
					if (mac_last) begin
						sxx_q   <= mac_acc_nxt[SQ_W-1:0];
						state_q <= ST_YY;
					end
				end
				ST_YY: begin
					if (mac_last) begin
						syy_q   <= mac_acc_nxt[SQ_W-1:0];
						state_q <= ST_XY;
					end
				end
				ST_XY: begin
					if (mac_last) begin
						sxy_q   <= mac_acc_nxt[XY_W-1:0];
						state_q <= last_q ? ST_U1 : ST_IDLE;
					end
				end
				ST_U1: if (mac_last) state_q <= ST_U2;
				ST_U2: if (mac_last) state_q <= ST_V1;
				ST_V1: if (mac_last) state_q <= ST_V2;
				ST_V2: if (mac_last) state_q <= ST_W1;
				ST_W1: if (mac_last) state_q <= ST_W2;
				ST_W2: if (mac_last) state_q <= ST_WABS;
				ST_WABS: begin
					state_q <= (u_q == '0 || v_q == '0) ? ST_DONE : ST_UV;
				end
				ST_UV: if (mac_last) state_q <= ST_WW;
				ST_WW: if (mac_last) state_q <= ST_R1;
				ST_R1: state_q <= ST_R2;
				ST_R2: state_q <= ST_R3;
				ST_R3: begin
					if (!alu_sum[BIG_W-1]) begin
						state_q <= ST_R4;
					end else begin
						state_q <= (bit_q == '0) ? ST_DONE : ST_R1;
					end
				end
				ST_R4: state_q <= (bit_q == '0) ? ST_DONE : ST_R1;
				ST_DONE: begin
					if (out_free) begin
						cnt_q    <= '0;
						sx_q     <= '0;
						sy_q     <= '0;
						sxx_q    <= '0;
						syy_q    <= '0;
						sxy_q    <= '0;
						ovf_q    <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: multiplier steps, operand loads, root search and result.
	// On the final multiplier bit the state below takes the product and loads
	// the operands of the next step.
	always_ff @(posedge clk) begin
		if (mac_busy && !mac_last) begin
			acc_q <= mac_acc_nxt;
			a_q   <= a_q << 1;
			b_q   <= b_q >> 1;
		end
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					x_q    <= pairs.sample_x;
					y_q    <= pairs.sample_y;
					last_q <= pairs.last_pair;
					sub_q  <= 1'b0;
					if (room) begin
						acc_q <= BIG_W'(sxx_q);
						a_q   <= BIG_W'(in_x_mag);
						b_q   <= U_W'(in_x_mag);
					end else begin
						acc_q <= '0;
						a_q   <= BIG_W'(sxx_q);
						b_q   <= U_W'(cnt_q);
					end
				end
			end
			ST_XX: begin
				if (mac_last) begin
					acc_q <= BIG_W'(syy_q);
					a_q   <= BIG_W'(y_mag);
					b_q   <= U_W'(y_mag);
					sub_q <= 1'b0;
				end
			end
			ST_YY: begin
				if (mac_last) begin
					acc_q <= BIG_W'(sxy_q);
					a_q   <= BIG_W'(x_mag);
					b_q   <= U_W'(y_mag);
					sub_q <= x_q[SMP_W-1] ^ y_q[SMP_W-1];
				end
			end
			ST_XY: begin
				if (mac_last) begin
					acc_q <= '0;
					a_q   <= BIG_W'(sxx_q);
					b_q   <= U_W'(cnt_q);
					sub_q <= 1'b0;
				end
			end
			ST_U1: begin
				if (mac_last) begin
					acc_q <= mac_acc_nxt;
					a_q   <= BIG_W'(sx_mag);
					b_q   <= U_W'(sx_mag);
					sub_q <= 1'b1;
				end
			end
			ST_U2: begin
				if (mac_last) begin
					u_q   <= mac_acc_nxt[U_W-1:0];
					acc_q <= '0;
					a_q   <= BIG_W'(syy_q);
					b_q   <= U_W'(cnt_q);
					sub_q <= 1'b0;
				end
			end
			ST_V1: begin
				if (mac_last) begin
					acc_q <= mac_acc_nxt;
					a_q   <= BIG_W'(sy_mag);
					b_q   <= U_W'(sy_mag);
					sub_q <= 1'b1;
				end
			end
			ST_V2: begin
				if (mac_last) begin
					v_q   <= mac_acc_nxt[U_W-1:0];
					acc_q <= '0;
					a_q   <= BIG_W'(sxy_mag);
					b_q   <= U_W'(cnt_q);
					sub_q <= sxy_q[XY_W-1];
				end
			end
			ST_W1: begin
				// Subtracting sx*sy flips the sign of that product.
				if (mac_last) begin
					acc_q <= mac_acc_nxt;
					a_q   <= BIG_W'(sx_mag);
					b_q   <= U_W'(sy_mag);
					sub_q <= ~(sx_q[SUM_W-1] ^ sy_q[SUM_W-1]);
				end
			end
			ST_W2: begin
				if (mac_last) begin
					acc_q <= mac_acc_nxt;
				end
			end
			ST_WABS: begin
				// Split the covariance term into sign and magnitude; load u*v.
				wneg_q <= acc_q[BIG_W-1];
				wmag_q <= alu_sum[U_W-1:0];
				flat_q <= (u_q == '0 || v_q == '0);
				k_q    <= '0;
				acc_q  <= '0;
				a_q    <= BIG_W'(u_q);
				b_q    <= v_q;
				sub_q  <= 1'b0;
			end
			ST_UV: begin
				if (mac_last) begin
					uv_q  <= mac_acc_nxt[2*U_W-1:0];
					acc_q <= '0;
					a_q   <= BIG_W'(wmag_q);
					b_q   <= wmag_q;
					sub_q <= 1'b0;
				end
			end
			ST_WW: begin
				// Root search for the largest k with k*k*u*v <= w*w*2^32.
				if (mac_last) begin
					ww_q  <= mac_acc_nxt << pcorr_pkg::FRAC_SH;
					p_q   <= '0;
					r_q   <= '0;
					s_q   <= BIG_W'(uv_q) << pcorr_pkg::FRAC_SH;
					k_q   <= '0;
					bit_q <= BIT_W'(KEY_W - 1);
				end
			end
			ST_R1: acc_q <= alu_sum;
			ST_R2: acc_q <= alu_sum;
			ST_R3: begin
				// Trial square within bound: keep the bit, else move on.
				if (!alu_sum[BIG_W-1]) begin
					p_q        <= acc_q;
					k_q[bit_q] <= 1'b1;
				end else begin
					r_q   <= r_q >> 1;
					s_q   <= s_q >> 2;
					bit_q <= bit_q - 1'b1;
				end
			end
			ST_R4: begin
				r_q   <= alu_sum;
				s_q   <= s_q >> 2;
				bit_q <= bit_q - 1'b1;
			end
			ST_DONE: begin
				if (out_free) begin
					if (flat_q) begin
						coef_q <= '0;
					end else begin
						coef_q <= wneg_q ? COEF_W'(-mag_sat) : mag_sat;
					end
					flat_out_q <= flat_q;
					long_out_q <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking testbench of pearson_correlation
// Sample pairs are streamed in over the valid/ready channel, grouped into
// series closed by the last-pair mark. Each coefficient beat is checked against
// an exact integer predictor. Both sides idle at random, and the result side
// holds off for a long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb;

	localparam int HOLD_AT_PAIR = 120;
	localparam int HOLD_CYCLES  = 3000;
	localparam int TAIL_CYCLES  = 400;
	localparam int RANDOM_BULK  = 480;
	localparam int RANDOM_TOTAL = 550;

	typedef logic signed [pcorr_pkg::SMP_W-1:0] sample_t;

	typedef struct packed {
		sample_t x;
		sample_t y;
		logic    last;
	} pair_t;

	typedef struct packed {
		logic [pcorr_pkg::COEF_W-1:0] coefficient;
		logic                         flat_series;
		logic                         too_long;
	} corr_t;

	// How the samples of one random series are drawn.
	typedef enum int {
		MODE_FULL,
		MODE_SMALL,
		MODE_CORNER,
		MODE_LINKED
	} value_mode_e;

	logic clk = 1'b0;
	logic arst_n;

	pcorr_in_if  pairs_if ();
	pcorr_out_if result_if ();

	pearson_correlation u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pairs  (pairs_if),
		.result (result_if)
	);

	// Running sums of the series in progress, kept exactly.
	int unsigned run_count;
	longint      run_sx, run_sy, run_sxx, run_syy, run_sxy;
	logic        run_over;

	pair_t pending_pairs[$];
	corr_t expected_coefs[$];
	pair_t next_pair;
	corr_t want;

	int  n_pushed;
	int  n_pairs_in;
	int  n_errors;
	int  send_gap;
	int  recv_gap;
	int  hold_left;
	logic hold_done;
	logic calm;

	// Clock: 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Adds one pair to the running sums; on the last pair of a series it works
	// out the coefficient and flags, queues them and clears the sums.
	function automatic void accumulate_pair(input sample_t x, input sample_t y,
		input logic last);
		longint       n, u, v, w, odd;
		logic [63:0]  w_mag;
		logic [199:0] uv_big, w2_big, trial;
		int           lo, hi, mid;
		logic         neg, flat;
		corr_t        res;
		if (run_count < pcorr_pkg::N_MAX) begin
			run_count++;
			run_sx  += longint'(x);
			run_sy  += longint'(y);
			run_sxx += longint'(x) * longint'(x);
			run_syy += longint'(y) * longint'(y);
			run_sxy += longint'(x) * longint'(y);
		end else begin
			run_over = 1'b1;
		end
		if (!last)
			return;

		n = longint'(run_count);
		u = n * run_sxx - run_sx * run_sx;
		v = n * run_syy - run_sy * run_sy;
		w = n * run_sxy - run_sx * run_sy;
		neg = (w < 0);
		w_mag = neg ? -w : w;
		flat = (u <= 0) || (v <= 0);
		lo = 0;
		hi = 32768;

		// Largest m with (2m-1)^2 * u*v <= 2^32 * w^2, i.e. round to nearest.
		if (!flat) begin
			uv_big = 200'(u) * 200'(v);
			w2_big = (200'(w_mag) * 200'(w_mag)) << 32;
			while (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				odd = 2 * mid - 1;
				trial = 200'(odd * odd) * uv_big;
				if (trial <= w2_big)
					lo = mid;
				else
					hi = mid - 1;
			end
		end
		if (lo > int'(pcorr_pkg::COEF_MAX))
			lo = int'(pcorr_pkg::COEF_MAX);

		res.coefficient = neg ? pcorr_pkg::COEF_W'(-lo) : pcorr_pkg::COEF_W'(lo);
		res.flat_series = flat;
		res.too_long    = run_over;
		expected_coefs.push_back(res);

		run_count = 0;
		run_sx = 0;
		run_sy = 0;
		run_sxx = 0;
		run_syy = 0;
		run_sxy = 0;
		run_over = 1'b0;
	endfunction

	function automatic sample_t draw_sample(input value_mode_e mode);
		case (mode)
			MODE_SMALL: begin
				return sample_t'(int'($urandom_range(0, 8)) - 4);
			end
			MODE_CORNER: begin
				case ($urandom_range(0, 5))
					0: return 16'sh8000;
					1: return 16'sh8001;
					2: return -16'sd1;
					3: return 16'sd0;
					4: return 16'sd1;
					default: return 16'sh7FFF;
				endcase
			end
			default: begin
				return sample_t'($urandom);
			end
		endcase
	endfunction

	task automatic push_pair(input sample_t x, input sample_t y, input logic last);
		pending_pairs.push_back('{x, y, last});
		n_pushed++;
	endtask

	// One series of the given length; in linked mode y follows x with a slope
	// of -1, 0 or +1 plus a little noise, so strong correlations turn up.
	task automatic push_series(input int len, input value_mode_e mode);
		sample_t x, y;
		int      slope, t;
		slope = int'($urandom_range(0, 2)) - 1;
		for (int i = 0; i < len; i++) begin
			x = draw_sample(mode);
			y = draw_sample(mode);
			if (mode == MODE_LINKED) begin
				t = slope * int'(x) + int'($urandom_range(0, 64)) - 32;
				if (t > 32767)
					t = 32767;
				if (t < -32768)
					t = -32768;
				y = sample_t'(t);
			end
			push_pair(x, y, i == len - 1);
		end
	endtask

	task automatic push_random_series();
		int          len;
		value_mode_e mode;
		case ($urandom_range(0, 9))
			0:       len = 1;
			1, 2:    len = $urandom_range(11, 40);
			default: len = $urandom_range(2, 10);
		endcase
		mode = value_mode_e'($urandom_range(0, 3));
		push_series(len, mode);
	endtask

	// Waits until every pair has gone in and every coefficient has come out.
	task automatic wait_drained();
		while (pending_pairs.size() != 0 || pairs_if.valid || expected_coefs.size() != 0)
			@(negedge clk);
	endtask

	// Pair driver: offers queued pairs, with random idle bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs_if.valid     <= 1'b0;
			pairs_if.sample_x  <= '0;
			pairs_if.sample_y  <= '0;
			pairs_if.last_pair <= 1'b0;
			send_gap           <= 0;
			n_pairs_in         <= 0;
		end else begin
			if (pairs_if.valid && pairs_if.ready) begin
				accumulate_pair(pairs_if.sample_x, pairs_if.sample_y, pairs_if.last_pair);
				n_pairs_in <= n_pairs_in + 1;
			end
			if (!pairs_if.valid || pairs_if.ready) begin
				if (send_gap != 0) begin
					send_gap       <= send_gap - 1;
					pairs_if.valid <= 1'b0;
				end else if (!calm && pending_pairs.size() != 0 &&
					$urandom_range(0, 7) == 0) begin
					// This cycle starts an idle burst; send_gap holds its random remainder.
					send_gap       <= $urandom_range(0, 15);
					pairs_if.valid <= 1'b0;
				end else if (pending_pairs.size() != 0) begin
					next_pair = pending_pairs.pop_front();
					pairs_if.sample_x  <= next_pair.x;
					pairs_if.sample_y  <= next_pair.y;
					pairs_if.last_pair <= next_pair.last;
					pairs_if.valid     <= 1'b1;
				end else begin
					pairs_if.valid <= 1'b0;
				end
			end
		end
	end

	// Long hold-off of the result side, started once enough pairs have gone in.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && n_pairs_in >= HOLD_AT_PAIR) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Result monitor: checks each accepted beat and drives ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			recv_gap        <= 0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				if (expected_coefs.size() == 0) begin
					$display("%0t: result beat with none expected: coefficient %0d flat %b long %b",
						$time, $signed(result_if.coefficient), result_if.flat_series,
						result_if.too_long);
					n_errors++;
				end else begin
					want = expected_coefs.pop_front();
					if (result_if.coefficient !== want.coefficient) begin
						$display("%0t: coefficient expected %0d actual %0d", $time,
							$signed(want.coefficient), $signed(result_if.coefficient));
						n_errors++;
					end
					if (result_if.flat_series !== want.flat_series) begin
						$display("%0t: flat_series expected %b actual %b", $time,
							want.flat_series, result_if.flat_series);
						n_errors++;
					end
					if (result_if.too_long !== want.too_long) begin
						$display("%0t: too_long expected %b actual %b", $time,
							want.too_long, result_if.too_long);
						n_errors++;
					end
				end
			end
			if (recv_gap != 0) begin
				recv_gap        <= recv_gap - 1;
				result_if.ready <= 1'b0;
			end else if (hold_left != 0) begin
				result_if.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				recv_gap        <= $urandom_range(0, 15);
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		pairs_if.valid     = 1'b0;
		pairs_if.sample_x  = '0;
		pairs_if.sample_y  = '0;
		pairs_if.last_pair = 1'b0;
		result_if.ready    = 1'b0;
		calm      = 1'b0;
		n_errors  = 0;
		n_pushed  = 0;
		run_count = 0;
		run_sx    = 0;
		run_sy    = 0;
		run_sxx   = 0;
		run_syy   = 0;
		run_sxy   = 0;
		run_over  = 1'b0;
		arst_n    = 1'b0;

		// A single pair has no spread, so it is a flat series.
		push_pair(16'sh7FFF, 16'sh8000, 1'b1);
		// Perfect positive correlation saturates to the largest code.
		push_pair(16'sh8000, 16'sh8000, 1'b0);
		push_pair(16'sh7FFF, 16'sh7FFF, 1'b0);
		push_pair(16'sd0, 16'sd0, 1'b1);
		// Perfect negative correlation saturates to minus the largest code.
		push_pair(16'sh8000, 16'sh7FFF, 1'b0);
		push_pair(16'sh7FFF, 16'sh8000, 1'b1);
		// Constant y series: flat.
		push_pair(16'sd5, 16'sd7, 1'b0);
		push_pair(16'sd100, 16'sd7, 1'b0);
		push_pair(16'sh8000, 16'sd7, 1'b1);
		// A mixed series with every extreme of both samples.
		push_pair(16'sd1, -16'sd1, 1'b0);
		push_pair(-16'sd1, -16'sd1, 1'b0);
		push_pair(16'sh7FFF, 16'sd0, 1'b0);
		push_pair(16'sd0, 16'sh7FFF, 1'b0);
		push_pair(16'sh8000, 16'sh8000, 1'b0);
		push_pair(16'sd123, -16'sd456, 1'b1);
		// Uncorrelated but not flat: zero covariance.
		push_pair(16'sd1, 16'sd1, 1'b0);
		push_pair(-16'sd1, 16'sd1, 1'b0);
		push_pair(16'sd1, -16'sd1, 1'b0);
		push_pair(-16'sd1, -16'sd1, 1'b1);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The sender pauses here until every coefficient has come out.
		wait_drained();

		n_pushed = 0;
		while (n_pushed < RANDOM_BULK / 2)
			push_random_series();

		// A series one pair past the limit: the sums fill to exactly the limit
		// and the closing pair is dropped.
		push_series(pcorr_pkg::N_MAX + 1, MODE_SMALL);
		n_pushed -= pcorr_pkg::N_MAX + 1;

		while (n_pushed < RANDOM_BULK)
			push_random_series();

		// No idling on either side for the final stretch.
		while (pending_pairs.size() != 0)
			@(negedge clk);
		calm = 1'b1;
		while (n_pushed < RANDOM_TOTAL)
			push_random_series();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (n_errors == 0 && expected_coefs.size() == 0)
			$display("pearson_correlation test passed");
		else
			$display("pearson_correlation test failed");
		$finish;
	end

	// Guard against a hang.
	initial begin
		#20000000;
		$display("%0t: timeout with %0d pairs queued and %0d results outstanding", $time,
			pending_pairs.size(), expected_coefs.size());
		$display("pearson_correlation test failed");
		$finish;
	end

endmodule

FILE: pearson_correlation.f
rtl/pcorr_pkg.sv
rtl/pcorr_if.sv
rtl/pcorr_alu.sv
rtl/pearson_correlation.sv
dv/tb.sv
